// File: sv/lsrc_pkg.sv
// shared types, constants, lane setup and divider step for the segment clipper
`default_nettype none
package lsrc_pkg;

  localparam int COORD_W    = 24;
  localparam int COORD_FRAC = 8;
  localparam int T_W        = 17;
  localparam int T_FRAC     = 16;
  localparam int DELTA_W    = COORD_W + 1;
  localparam int EDGE_W     = COORD_W + 2;
  localparam int MAG_W      = COORD_W;
  localparam int DIV_STEPS  = T_FRAC;
  localparam int PROD_W     = DELTA_W + T_W + 1;
  localparam int CFG_W      = 16;
  localparam int SIZE_W     = 15;
  localparam int NUM_EDGES  = 4;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } lsrc_reg_t;

  // one edge quotient in flight
  typedef struct packed {
    logic                par;
    logic                par_ok;
    logic                enter;
    logic                fixed;
    logic [T_W-1:0]      fixv;
    logic [MAG_W-1:0]    dvs;
    logic [MAG_W-1:0]    rem;
    logic [T_FRAC-1:0]   quo;
  } lsrc_lane_t;

  // segment payload that rides along the divider
  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [T_W-1:0]            t0;
    logic [T_W-1:0]            t1;
    logic                      trej;
  } lsrc_seg_t;

  typedef lsrc_lane_t [NUM_EDGES-1:0] lsrc_lanes_t;

  // one restoring division step, one quotient bit
  function automatic lsrc_lane_t div_step(input lsrc_lane_t l);
    lsrc_lane_t        o;
    logic [MAG_W:0]    rem2;
    logic [MAG_W:0]    diff;
    o    = l;
    rem2 = {l.rem, 1'b0};
    diff = rem2 - {1'b0, l.dvs};
    if (rem2 >= {1'b0, l.dvs}) begin
      o.rem = diff[MAG_W-1:0];
      o.quo = {l.quo[T_FRAC-2:0], 1'b1};
    end else begin
      o.rem = rem2[MAG_W-1:0];
      o.quo = {l.quo[T_FRAC-2:0], 1'b0};
    end
    return o;
  endfunction

  // set up one edge: sign and saturation cases resolved up front
  function automatic lsrc_lane_t lane_prep(input logic signed [DELTA_W-1:0] p,
                                           input logic signed [EDGE_W-1:0] q);
    lsrc_lane_t          o;
    logic [DELTA_W-1:0]  pa;
    logic [EDGE_W-1:0]   qa;
    pa       = p[DELTA_W-1] ? DELTA_W'(-p) : DELTA_W'(p);
    qa       = q[EDGE_W-1] ? EDGE_W'(-q) : EDGE_W'(q);
    o.par    = (p == '0);
    o.par_ok = !q[EDGE_W-1];
    o.enter  = p[DELTA_W-1];
    o.dvs    = pa[MAG_W-1:0];
    o.rem    = qa[MAG_W-1:0];
    o.quo    = '0;
    o.fixv   = '0;
    o.fixed  = 1'b0;
    if ((p[DELTA_W-1] ^ q[EDGE_W-1]) && (q != '0)) begin
      o.fixed = 1'b1;
    end else if (qa >= EDGE_W'(pa)) begin
      o.fixed = 1'b1;
      o.fixv  = T_ONE;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// File: sv/line_segment_rect_clipper.sv
// segment clipper against a configured rectangle, fully pipelined
// Takes one segment per cycle whenever start is high; busy is always low.
// Each segment gives exactly one result, strobed by out_valid for a single
// cycle, after the input register, the edge dividers (one quotient
// bit per stage over 16 stages) and the combine, product and round stages.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module line_segment_rect_clipper (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [lsrc_pkg::COORD_W-1:0]  in_x_start,
  input  wire logic signed [lsrc_pkg::COORD_W-1:0]  in_y_start,
  input  wire logic signed [lsrc_pkg::COORD_W-1:0]  in_x_end,
  input  wire logic signed [lsrc_pkg::COORD_W-1:0]  in_y_end,
  input  wire logic [lsrc_pkg::T_W-1:0]             in_t_start,
  input  wire logic [lsrc_pkg::T_W-1:0]             in_t_end,
  output logic                                      out_valid,
  output logic                                      out_visible,
  output logic signed [lsrc_pkg::COORD_W-1:0]       out_clip_x_start,
  output logic signed [lsrc_pkg::COORD_W-1:0]       out_clip_y_start,
  output logic signed [lsrc_pkg::COORD_W-1:0]       out_clip_x_end,
  output logic signed [lsrc_pkg::COORD_W-1:0]       out_clip_y_end,
  input  wire logic                                 cfg_we,
  input  wire logic [1:0]                           cfg_index,
  input  wire logic [lsrc_pkg::CFG_W-1:0]           cfg_data
);
  import lsrc_pkg::*;

  // configuration registers
  logic signed [CFG_W-1:0] left_r, top_r;
  logic [SIZE_W-1:0]       width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_we) begin
      case (lsrc_reg_t'(cfg_index))
        REG_LEFT:   left_r   <= cfg_data;
        REG_TOP:    top_r    <= cfg_data;
        REG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: input beat register
  logic                      in_v_r;
  logic signed [COORD_W-1:0] x1_r, y1_r, x2_r, y2_r;
  logic [T_W-1:0]            t0_r, t1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) in_v_r <= 1'b0;
    else        in_v_r <= start;
  end

  always_ff @(posedge clk) begin
    x1_r <= in_x_start;
    y1_r <= in_y_start;
    x2_r <= in_x_end;
    y2_r <= in_y_end;
    t0_r <= in_t_start;
    t1_r <= in_t_end;
  end

  // stage 1: rectangle edges, deltas, trivial reject, lane setup
  logic signed [EDGE_W-1:0]  e_left, e_top, e_right, e_bottom;
  logic signed [EDGE_W-1:0]  ex1, ey1, ex2, ey2;
  logic signed [DELTA_W-1:0] dx, dy;
  logic                      trej;
  lsrc_seg_t                 seg_nxt;
  lsrc_lanes_t               lanes_nxt;

  always_comb begin
    e_left   = EDGE_W'($signed({left_r, {COORD_FRAC{1'b0}}}));
    e_top    = EDGE_W'($signed({top_r, {COORD_FRAC{1'b0}}}));
    e_right  = e_left + $signed(EDGE_W'({width_r, {COORD_FRAC{1'b0}}}));
    e_bottom = e_top + $signed(EDGE_W'({height_r, {COORD_FRAC{1'b0}}}));
    ex1 = EDGE_W'(x1_r);
    ey1 = EDGE_W'(y1_r);
    ex2 = EDGE_W'(x2_r);
    ey2 = EDGE_W'(y2_r);
    dx  = DELTA_W'(x2_r) - DELTA_W'(x1_r);
    dy  = DELTA_W'(y2_r) - DELTA_W'(y1_r);
    trej = (t0_r == '0) && (t1_r == T_ONE) &&
           ((ex1 < e_left && ex2 < e_left) || (ex1 > e_right && ex2 > e_right) ||
            (ey1 < e_top && ey2 < e_top) || (ey1 > e_bottom && ey2 > e_bottom));
    seg_nxt.x1   = x1_r;
    seg_nxt.y1   = y1_r;
    seg_nxt.dx   = dx;
    seg_nxt.dy   = dy;
    seg_nxt.t0   = t0_r;
    seg_nxt.t1   = t1_r;
    seg_nxt.trej = trej;
    lanes_nxt[0] = lane_prep(-dx, ex1 - e_left);
    lanes_nxt[1] = lane_prep(dx, e_right - ex1);
    lanes_nxt[2] = lane_prep(-dy, ey1 - e_top);
    lanes_nxt[3] = lane_prep(dy, e_bottom - ey1);
  end

  // divider pipeline, one quotient bit per stage
  logic        dv_r   [DIV_STEPS+1];
  lsrc_seg_t   dseg_r [DIV_STEPS+1];
  lsrc_lanes_t dln_r  [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STEPS; k++) dv_r[k] <= 1'b0;
    end else begin
      dv_r[0] <= in_v_r;
      for (int k = 0; k < DIV_STEPS; k++) dv_r[k+1] <= dv_r[k];
    end
  end

  always_ff @(posedge clk) begin
    dseg_r[0] <= seg_nxt;
    dln_r[0]  <= lanes_nxt;
    for (int k = 0; k < DIV_STEPS; k++) begin
      dseg_r[k+1] <= dseg_r[k];
      for (int e = 0; e < NUM_EDGES; e++) dln_r[k+1][e] <= div_step(dln_r[k][e]);
    end
  end

  // combine the edge results into the final window
  logic           cv_r, cvis_r;
  lsrc_seg_t      cseg_r;
  logic [T_W-1:0] ct0_r, ct1_r;
  logic [T_W-1:0] t0_nxt, t1_nxt, r;
  logic           bad, anynp, vis_nxt;
  lsrc_lanes_t    fl;

  always_comb begin
    fl     = dln_r[DIV_STEPS];
    t0_nxt = dseg_r[DIV_STEPS].t0;
    t1_nxt = dseg_r[DIV_STEPS].t1;
    bad    = dseg_r[DIV_STEPS].trej;
    anynp  = 1'b0;
    r      = '0;
    for (int e = 0; e < NUM_EDGES; e++) begin
      r = fl[e].fixed ? fl[e].fixv : T_W'(fl[e].quo);
      if (fl[e].par) begin
        if (!fl[e].par_ok) bad = 1'b1;
      end else begin
        anynp = 1'b1;
        if (fl[e].enter) begin
          if (r > t0_nxt) t0_nxt = r;
        end else begin
          if (r < t1_nxt) t1_nxt = r;
        end
      end
    end
    vis_nxt = !bad && !(anynp && (t0_nxt >= t1_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r <= 1'b0;
    else        cv_r <= dv_r[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    cseg_r <= dseg_r[DIV_STEPS];
    ct0_r  <= t0_nxt;
    ct1_r  <= t1_nxt;
    cvis_r <= vis_nxt;
  end

  // interpolation products
  logic                      mv_r, mvis_r;
  logic signed [COORD_W-1:0] mx1_r, my1_r;
  logic signed [PROD_W-1:0]  px0_r, py0_r, px1_r, py1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mv_r <= 1'b0;
    else        mv_r <= cv_r;
  end

  always_ff @(posedge clk) begin
    mvis_r <= cvis_r;
    mx1_r  <= cseg_r.x1;
    my1_r  <= cseg_r.y1;
    px0_r  <= PROD_W'(cseg_r.dx) * PROD_W'($signed({1'b0, ct0_r}));
    py0_r  <= PROD_W'(cseg_r.dy) * PROD_W'($signed({1'b0, ct0_r}));
    px1_r  <= PROD_W'(cseg_r.dx) * PROD_W'($signed({1'b0, ct1_r}));
    py1_r  <= PROD_W'(cseg_r.dy) * PROD_W'($signed({1'b0, ct1_r}));
  end

  // round to nearest and add the start point
  function automatic logic signed [COORD_W-1:0] lerp_fin(
      input logic signed [COORD_W-1:0] a, input logic signed [PROD_W-1:0] pr);
    logic signed [PROD_W-1:0] s;
    s = (pr + PROD_W'(1 << (T_FRAC - 1))) >>> T_FRAC;
    return COORD_W'(a + s[COORD_W-1:0]);
  endfunction

  logic                      ov_r, ovis_r;
  logic signed [COORD_W-1:0] ox0_r, oy0_r, ox1_r, oy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= mv_r;
  end

  always_ff @(posedge clk) begin
    ovis_r <= mvis_r;
    ox0_r  <= mvis_r ? lerp_fin(mx1_r, px0_r) : '0;
    oy0_r  <= mvis_r ? lerp_fin(my1_r, py0_r) : '0;
    ox1_r  <= mvis_r ? lerp_fin(mx1_r, px1_r) : '0;
    oy1_r  <= mvis_r ? lerp_fin(my1_r, py1_r) : '0;
  end

  assign out_valid        = ov_r;
  assign out_visible      = ovis_r;
  assign out_clip_x_start = ox0_r;
  assign out_clip_y_start = oy0_r;
  assign out_clip_x_end   = ox1_r;
  assign out_clip_y_end   = oy1_r;

endmodule
`default_nettype wire

// File: test/line_segment_rect_clipper_test.sv
// self-checking testbench for the segment clipper: directed and random segments
`default_nettype none
module line_segment_rect_clipper_test;
  import lsrc_pkg::*;

  localparam int LATENCY   = 21;
  localparam int N_RANDOM  = 1800;
  localparam int MAX_CYC   = 400000;

  typedef struct packed {
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] xe;
    logic signed [COORD_W-1:0] ye;
    logic [T_W-1:0]            ts;
    logic [T_W-1:0]            te;
  } seg_t;

  typedef struct packed {
    logic                      vis;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] xe;
    logic signed [COORD_W-1:0] ye;
  } clip_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] in_x_start = '0, in_y_start = '0, in_x_end = '0, in_y_end = '0;
  logic [T_W-1:0] in_t_start = '0, in_t_end = '0;
  logic out_valid, out_visible;
  logic signed [COORD_W-1:0] out_clip_x_start, out_clip_y_start, out_clip_x_end, out_clip_y_end;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_LEFT;
  logic [CFG_W-1:0] cfg_data = '0;

  line_segment_rect_clipper dut (.*);

  // rectangle as the predictor sees it
  logic signed [15:0] rect_left = 0, rect_top = 0;
  logic [14:0] rect_width = 0, rect_height = 0;

  seg_t  pending_segs[$];
  clip_t expected_clips[$];
  int errors = 0;
  int cycles = 0;
  int segs_sent = 0;
  int clips_seen = 0;
  int visible_seen = 0;
  bit feeding = 1'b1;

  initial forever #6 clk = ~clk;

  // one edge update; returns 0 when the segment drops out
  function automatic bit edge_update(inout longint t0, inout longint t1, input longint p,
                                     input longint q);
    longint r;
    if (p == 0) return q >= 0;
    r = (q * 65536) / p;
    if (r < 0) r = 0;
    if (r > 65536) r = 65536;
    if (p < 0) begin
      if (r > t0) t0 = r;
    end else begin
      if (r < t1) t1 = r;
    end
    return t0 < t1;
  endfunction

  function automatic longint interp(longint a, longint d, longint t);
    return a + ((d * t + 32768) >>> 16);
  endfunction

  function automatic clip_t clip_segment(seg_t s);
    clip_t  c;
    longint lf, tp, rt, bt, x1, y1, x2, y2, dx, dy, t0, t1;
    bit     rej;
    lf = longint'(rect_left) * 256;
    tp = longint'(rect_top) * 256;
    rt = lf + longint'(rect_width) * 256;
    bt = tp + longint'(rect_height) * 256;
    x1 = s.xs; y1 = s.ys; x2 = s.xe; y2 = s.ye;
    t0 = s.ts; t1 = s.te;
    dx = x2 - x1; dy = y2 - y1;
    rej = (t0 == 0 && t1 == 65536 &&
           ((x1 < lf && x2 < lf) || (x1 > rt && x2 > rt) ||
            (y1 < tp && y2 < tp) || (y1 > bt && y2 > bt)));
    if (!rej) rej = !edge_update(t0, t1, -dx, x1 - lf);
    if (!rej) rej = !edge_update(t0, t1, dx, rt - x1);
    if (!rej) rej = !edge_update(t0, t1, -dy, y1 - tp);
    if (!rej) rej = !edge_update(t0, t1, dy, bt - y1);
    c = '0;
    if (!rej) begin
      c.vis = 1'b1;
      c.xs = COORD_W'(interp(x1, dx, t0));
      c.ys = COORD_W'(interp(y1, dy, t0));
      c.xe = COORD_W'(interp(x1, dx, t1));
      c.ye = COORD_W'(interp(y1, dy, t1));
    end
    return c;
  endfunction

  // driver: one beat per item with a random gap after it
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_clips.push_back(clip_segment(pending_segs.pop_front()));
        segs_sent++;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
      end
      if (gap > 0 && !(start && !busy && pending_segs.size() == 0)) begin
        gap--;
        start <= 1'b0;
      end else if (pending_segs.size() > 0 && feeding) begin
        start      <= 1'b1;
        in_x_start <= pending_segs[0].xs;
        in_y_start <= pending_segs[0].ys;
        in_x_end   <= pending_segs[0].xe;
        in_y_end   <= pending_segs[0].ye;
        in_t_start <= pending_segs[0].ts;
        in_t_end   <= pending_segs[0].te;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result beat against the oldest prediction
  always @(posedge clk) begin
    clip_t e;
    cycles++;
    if (rst_n && out_valid) begin
      clips_seen++;
      if (expected_clips.size() == 0) begin
        $error("result beat with no segment pending");
        errors++;
      end else begin
        e = expected_clips.pop_front();
        visible_seen += e.vis;
        if (out_visible !== e.vis) begin
          $error("visible: expected %0d got %0d", e.vis, out_visible); errors++;
        end
        if (out_clip_x_start !== e.xs) begin
          $error("clip_x_start: expected %0d got %0d", e.xs, out_clip_x_start); errors++;
        end
        if (out_clip_y_start !== e.ys) begin
          $error("clip_y_start: expected %0d got %0d", e.ys, out_clip_y_start); errors++;
        end
        if (out_clip_x_end !== e.xe) begin
          $error("clip_x_end: expected %0d got %0d", e.xe, out_clip_x_end); errors++;
        end
        if (out_clip_y_end !== e.ye) begin
          $error("clip_y_end: expected %0d got %0d", e.ye, out_clip_y_end); errors++;
        end
      end
    end
    if (cycles > MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("line_segment_rect_clipper_test: FAIL");
      $finish;
    end
  end

  task automatic write_reg(lsrc_reg_t idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LEFT:   rect_left   = val;
      REG_TOP:    rect_top    = val;
      REG_WIDTH:  rect_width  = val[14:0];
      REG_HEIGHT: rect_height = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_rect(logic [15:0] l, logic [15:0] t, logic [15:0] w, logic [15:0] h);
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // wait until the pipeline has drained
  task automatic drain();
    while (pending_segs.size() > 0 || start || expected_clips.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic seg_t seg(longint xs, longint ys, longint xe, longint ye,
                               longint ts, longint te);
    seg_t s;
    s.xs = COORD_W'(xs); s.ys = COORD_W'(ys); s.xe = COORD_W'(xe); s.ye = COORD_W'(ye);
    s.ts = T_W'(ts); s.te = T_W'(te);
    return s;
  endfunction

  // coordinate near the rectangle most of the time, anywhere otherwise
  function automatic logic [COORD_W-1:0] rand_coord(longint lo, longint span);
    case ($urandom_range(0, 5))
      0: return COORD_W'($urandom);
      1: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      default: return COORD_W'(lo * 256 - 2048 + longint'($urandom_range(0, span * 256 + 4096)));
    endcase
  endfunction

  function automatic logic [T_W-1:0] rand_t(bit hi);
    case ($urandom_range(0, 7))
      0: return T_W'($urandom);
      1, 2, 3: return hi ? T_W'(65536) : T_W'(0);
      default: return T_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic random_phase(int n);
    seg_t s;
    for (int i = 0; i < n; i++) begin
      s.xs = rand_coord(rect_left, rect_width);
      s.ys = rand_coord(rect_top, rect_height);
      s.xe = rand_coord(rect_left, rect_width);
      s.ye = rand_coord(rect_top, rect_height);
      if ($urandom_range(0, 9) == 0) begin
        s.xe = s.xs;
        if ($urandom_range(0, 1)) s.ye = s.ys;
      end else if ($urandom_range(0, 9) == 0) s.ye = s.ys;
      s.ts = rand_t(0);
      s.te = rand_t(1);
      pending_segs.push_back(s);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset rectangle is a single point at the origin
    pending_segs.push_back(seg(0, 0, 0, 0, 0, 65536));
    pending_segs.push_back(seg(-256, 0, 256, 0, 0, 65536));
    drain();

    set_rect(16'd10, 16'd20, 16'd100, 16'd50);
    // fully inside, crossing, both beyond one edge, parallel outside
    pending_segs.push_back(seg(20*256, 30*256, 90*256, 60*256, 0, 65536));
    pending_segs.push_back(seg(0, 0, 200*256, 100*256, 0, 65536));
    pending_segs.push_back(seg(0, 30*256, 5*256, 60*256, 0, 65536));
    pending_segs.push_back(seg(0, 30*256, 5*256, 60*256, 0, 65535));
    pending_segs.push_back(seg(200*256, 30*256, 300*256, 60*256, 0, 65536));
    pending_segs.push_back(seg(20*256, 0, 20*256, 10*256, 0, 65536));
    pending_segs.push_back(seg(20*256, 0, 20*256, 100*256, 0, 65536));
    pending_segs.push_back(seg(0, 25*256, 300*256, 25*256, 1000, 60000));
    // point inside with empty window, point on edge, point outside
    pending_segs.push_back(seg(50*256, 40*256, 50*256, 40*256, 40000, 100));
    pending_segs.push_back(seg(10*256, 20*256, 10*256, 20*256, 0, 0));
    pending_segs.push_back(seg(5*256, 40*256, 5*256, 40*256, 0, 65536));
    // window above one, window with all bits set, reversed
    pending_segs.push_back(seg(20*256, 30*256, 90*256, 60*256, 0, 131071));
    pending_segs.push_back(seg(20*256, 30*256, 90*256, 60*256, 131071, 131071));
    pending_segs.push_back(seg(20*256, 30*256, 90*256, 60*256, 50000, 10000));
    // coordinate extremes
    pending_segs.push_back(seg(-8388608, -8388608, 8388607, 8388607, 0, 65536));
    pending_segs.push_back(seg(8388607, -8388608, -8388608, 8388607, 0, 65536));
    pending_segs.push_back(seg(8388607, 8388607, -8388608, -8388608, 0, 131071));
    drain();

    // extreme rectangles, then random phases over several settings
    set_rect(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    pending_segs.push_back(seg(-8388608, -8388608, 8388607, 8388607, 0, 65536));
    random_phase(300);
    drain();
    set_rect(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    pending_segs.push_back(seg(8388607, 8388607, -8388608, -8388608, 0, 65536));
    random_phase(300);
    drain();
    set_rect(16'hffff, 16'h0000, 16'h0000, 16'h7fff);
    random_phase(300);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      set_rect(16'($urandom_range(0, 600)) - 16'd300, 16'($urandom_range(0, 600)) - 16'd300,
               16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)));
      random_phase(300);
      drain();
    end

    $display("%0d segments sent, %0d results checked, %0d visible, over 8 rectangles",
             segs_sent, clips_seen, visible_seen);
    if (errors == 0 && expected_clips.size() == 0) begin
      $display("line_segment_rect_clipper_test: PASS");
    end else begin
      $display("line_segment_rect_clipper_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
sv/lsrc_pkg.sv
sv/line_segment_rect_clipper.sv
test/line_segment_rect_clipper_test.sv
